@@ rtl/tmc_pkg.sv @@
// ----------------------------------------------------------------------------
// tmc_pkg: shared types and constants of the touch median calibrate unit
// Window size, sample width, link type of the sorting chain, state and
// register codes, and the clamp limit helper.
// ----------------------------------------------------------------------------
package tmc_pkg;

  localparam int WINDOW  = 7;
  localparam int MED_IDX = WINDOW / 2;
  localparam int CNT_W   = $clog2(WINDOW);
  localparam int SAMPLE_W = 13;
  localparam int OFS_W   = 14;
  localparam int GAIN_W  = 24;
  localparam int SIZE_W  = 11;
  localparam int COORD_W = 10;
  localparam int PROD_W  = OFS_W + GAIN_W;
  localparam int FRAC_W  = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COORD_W-1:0]  coord_t;

  // What one sorting cell hands to its right-hand neighbor.
  typedef struct packed {
    logic    gt;   // cell value is above the incoming sample, or cell is empty
    sample_t val;  // current cell value
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    REG_X_OFFSET     = 3'd0,
    REG_Y_OFFSET     = 3'd1,
    REG_X_GAIN       = 3'd2,
    REG_Y_GAIN       = 3'd3,
    REG_CALIB_LAND   = 3'd4,
    REG_DISPLAY_LAND = 3'd5,
    REG_SCREEN_H     = 3'd6,
    REG_SCREEN_W     = 3'd7
  } reg_e;

  // Largest pixel index for a screen size; zero acts as one, above 1024 as 1024.
  function automatic coord_t limit_of(logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] dec;
    dec = size - SIZE_W'(1);
    if (size == '0) begin
      limit_of = '0;
    end else if (size > SIZE_W'(1024)) begin
      limit_of = '1;
    end else begin
      limit_of = dec[COORD_W-1:0];
    end
  endfunction

endpackage

@@ rtl/touch_median_calibrate_unit.sv @@
// ----------------------------------------------------------------------------
// touch_median_calibrate_unit: median of seven touch samples per axis with
// linear calibration, clamping and orientation.
// Path: the last Y sample goes through the multiply state, the output state
// and the output register. Throughput: one sample per cycle; after each Y
// window the input stalls while the gain multipliers and the output stage run.
// Reset: async active low; clears sample count, axis, held X median, state,
// output valid and loads the calibration registers with their defaults.
// ----------------------------------------------------------------------------
module touch_median_calibrate_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // sample stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] hi_byte, [15:8] lo_byte
  input  logic        s_axis_tuser,   // [0] axis (0 X, 1 Y)
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [12:0] raw_x, [25:13] raw_y,
                                     // [35:26] screen_x, [45:36] screen_y, pad
);
  import tmc_pkg::*;

  // Calibration registers
  logic [OFS_W-1:0]  x_offset_q, y_offset_q;
  logic [GAIN_W-1:0] x_gain_q, y_gain_q;
  logic              calib_land_q, display_land_q;
  logic [SIZE_W-1:0] screen_h_q, screen_w_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_offset_q     <= '0;
      y_offset_q     <= '0;
      x_gain_q       <= GAIN_W'(65536);
      y_gain_q       <= GAIN_W'(65536);
      calib_land_q   <= 1'b0;
      display_land_q <= 1'b0;
      screen_h_q     <= SIZE_W'(320);
      screen_w_q     <= SIZE_W'(240);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_X_OFFSET:     x_offset_q     <= cfg_data_i[OFS_W-1:0];
        REG_Y_OFFSET:     y_offset_q     <= cfg_data_i[OFS_W-1:0];
        REG_X_GAIN:       x_gain_q       <= cfg_data_i[GAIN_W-1:0];
        REG_Y_GAIN:       y_gain_q       <= cfg_data_i[GAIN_W-1:0];
        REG_CALIB_LAND:   calib_land_q   <= cfg_data_i[0];
        REG_DISPLAY_LAND: display_land_q <= cfg_data_i[0];
        REG_SCREEN_H:     screen_h_q     <= cfg_data_i[SIZE_W-1:0];
        REG_SCREEN_W:     screen_w_q     <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode
  state_e     state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic       axis_q, axis_d;
  sample_t    held_x_q, held_x_d;
  sample_t    med_y_q, med_y_d;
  sample_t    sample;
  logic       in_xfer, take;
  logic       last;

  assign sample  = {s_axis_tdata[7:0], s_axis_tdata[15:11]};
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  // Drop samples of the wrong axis without touching any state
  assign take    = in_xfer && (s_axis_tuser == axis_q);
  assign last    = (count_q == CNT_W'(WINDOW - 1));

  // Insertion chain: cell i is occupied when more than i samples of the window are taken
  link_t   links [WINDOW+1];
  sample_t vnext [WINDOW];

  assign links[0] = '{gt: 1'b0, val: '0};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    tmc_sort_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (take),
      .occ_i      ({1'b0, count_q} > (CNT_W+1)'(i)),
      .sample_i   (sample),
      .prev_i     (links[i]),
      .next_o     (links[i+1]),
      .val_next_o (vnext[i])
    );
  end

  // Calibration lanes
  logic   mul_load;
  coord_t h_lim, w_lim;
  coord_t x_cal, y_cal;

  assign h_lim = limit_of(screen_h_q);
  assign w_lim = limit_of(screen_w_q);

  tmc_scale u_scale_x (
    .clk_i    (clk_i),
    .load_i   (mul_load),
    .median_i (held_x_q),
    .offset_i (x_offset_q),
    .gain_i   (x_gain_q),
    .lim_i    (h_lim),
    .coord_o  (x_cal)
  );

  tmc_scale u_scale_y (
    .clk_i    (clk_i),
    .load_i   (mul_load),
    .median_i (med_y_q),
    .offset_i (y_offset_q),
    .gain_i   (y_gain_q),
    .lim_i    (w_lim),
    .coord_o  (y_cal)
  );

  // Swap for landscape calibration, then rotate when the display differs
  coord_t sw_x, sw_y, or_x, or_y;

  always_comb begin
    sw_x = calib_land_q ? y_cal : x_cal;
    sw_y = calib_land_q ? x_cal : y_cal;
    or_x = sw_x;
    or_y = sw_y;
    if (calib_land_q != display_land_q) begin
      if (!calib_land_q) begin
        or_x = w_lim - sw_y;
        or_y = sw_x;
      end else begin
        or_x = sw_y;
        or_y = w_lim - sw_x;
      end
    end
  end

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [47:0] out_data_q;
  logic        out_load;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    axis_d      = axis_q;
    held_x_d    = held_x_q;
    med_y_d     = med_y_q;
    s_axis_tready = 1'b0;
    mul_load    = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (take) begin
          if (last) begin
            count_d = '0;
            axis_d  = !axis_q;
            if (!axis_q) begin
              held_x_d = vnext[MED_IDX];
            end else begin
              med_y_d = vnext[MED_IDX];
              state_d = ST_MUL;
            end
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      ST_MUL: begin
        mul_load = 1'b1;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      axis_q      <= 1'b0;
      held_x_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      axis_q      <= axis_d;
      held_x_q    <= held_x_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    med_y_q <= med_y_d;
    if (out_load) begin
      out_data_q <= {2'b00, or_y, or_x, med_y_q, held_x_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Assertions
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} < (CNT_W+1)'(WINDOW)))
    else $error("sample count left the window");

  a_mul_after_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (!axis_q && count_q == '0))
    else $error("multiply stage entered without a finished Y window");

  a_mul_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> (state_q == ST_FIN))
    else $error("multiply stage not followed by output stage");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the output stage");

endmodule

@@ rtl/tmc_sort_cell.sv @@
// ----------------------------------------------------------------------------
// tmc_sort_cell: one cell of the insertion sorting chain
// Holds one sample; on a load it keeps its value, takes the new sample or
// takes its left neighbor's value so that the chain stays in ascending order.
// ----------------------------------------------------------------------------
module tmc_sort_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            occ_i,
  input  tmc_pkg::sample_t sample_i,
  input  tmc_pkg::link_t  prev_i,
  output tmc_pkg::link_t  next_o,
  output tmc_pkg::sample_t val_next_o
);
  import tmc_pkg::*;

  sample_t val_q, val_d;
  logic    gt;

  assign gt = !occ_i || (val_q > sample_i);

  always_comb begin
    val_d = val_q;
    if (load_i && gt) begin
      val_d = prev_i.gt ? prev_i.val : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign next_o.gt  = gt;
  assign next_o.val = val_q;
  assign val_next_o = val_d;

endmodule

@@ rtl/tmc_scale.sv @@
// ----------------------------------------------------------------------------
// tmc_scale: offset, gain and clamp of one axis
// Registers the product of (median - offset) and the Q8.16 gain, then drops
// the fraction and clamps to the given limit; non-positive differences give 0.
// ----------------------------------------------------------------------------
module tmc_scale (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  tmc_pkg::sample_t             median_i,
  input  logic [tmc_pkg::OFS_W-1:0]    offset_i,
  input  logic [tmc_pkg::GAIN_W-1:0]   gain_i,
  input  tmc_pkg::coord_t              lim_i,
  output tmc_pkg::coord_t              coord_o
);
  import tmc_pkg::*;

  logic signed [OFS_W:0]  diff;
  logic [PROD_W-1:0]      prod_q;
  logic                   pos_q;
  logic [PROD_W-FRAC_W-1:0] whole;

  assign diff = $signed({2'b00, median_i}) - $signed({offset_i[OFS_W-1], offset_i});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= PROD_W'(diff[OFS_W-1:0]) * PROD_W'(gain_i);
      pos_q  <= !diff[OFS_W] && (diff != '0);
    end
  end

  assign whole = prod_q[PROD_W-1:FRAC_W];

  always_comb begin
    if (!pos_q) begin
      coord_o = '0;
    end else if (whole > (PROD_W-FRAC_W)'(lim_i)) begin
      coord_o = lim_i;
    end else begin
      coord_o = whole[COORD_W-1:0];
    end
  end

endmodule
